[design/int128_to_decimal_text_assert.svh]
// Assertion macros for the int128_to_decimal_text design files.
// No dependencies; include after the module's port list.
`ifndef INT128_TO_DECIMAL_TEXT_ASSERT_SVH
`define INT128_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define I2DT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("int128_to_decimal_text: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define I2DT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("int128_to_decimal_text: assertion failed");

`endif

[design/i2dt_pkg.sv]
// Types and constants for the signed binary to decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package i2dt_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   localparam int unsigned HALF_W  = 64;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned CHAR_W  = 8;

   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 4'd3;

endpackage

[design/int128_to_decimal_text.sv]
// Top level of the signed binary to decimal text converter.
// Depends on i2dt_pkg and int128_to_decimal_text_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   req channel: one beat carries a VALUE_BITS-wide two's complement value as
//   two 64-bit halves; bits at or above VALUE_BITS are ignored.
//   rsp channel: one beat per ASCII character, most significant first: an
//   optional '-', then the digits without leading zeros ('0' for zero);
//   rsp_last marks the final character.
// Timing:
//   The magnitude is shifted one bit per cycle into a BCD register with
//   add-3 correction (double dabble) until all VALUE_BITS bits are in.
//   The digit register is then scanned one digit per cycle from the top,
//   DIGITS digits (39 at 128 bits), after a sign slot for a negative value,
//   and a digit that is sent waits for a free output. req_ready is high only
//   between values. A registered output stage lets the next value be
//   accepted while the final character still waits.
// Reset (synchronous, active high) returns the block to idle and drops any
// pending character. A stalled receiver freezes the character output; nothing is lost.

module int128_to_decimal_text #(
   parameter int unsigned VALUE_BITS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [i2dt_pkg::HALF_W-1:0]     req_value_high,
   input  logic [i2dt_pkg::HALF_W-1:0]     req_value_low,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [i2dt_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                            rsp_last
);

   import i2dt_pkg::*;

   localparam int unsigned DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned BCD_W     = DIGITS * DIGIT_W;
   localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int unsigned DIG_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [BCD_W-1:0]        bcd_adj;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                    started_ff, started_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [2*HALF_W-1:0]     req_full;
   logic [VALUE_BITS-1:0]   req_clip;
   logic                    out_free;
   logic [DIGIT_W-1:0]      top_digit;

   assign req_full  = {req_value_high, req_value_low};
   assign req_clip  = req_full[VALUE_BITS-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // add-3 correction on every digit before the shift
   always_comb begin
      logic [DIGIT_W-1:0] dig;
      for (int i = 0; i < DIGITS; i++) begin
         dig = bcd_ff[i*DIGIT_W +: DIGIT_W];
         bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= DIGIT_FIVE) ? dig + DIGIT_BIAS : dig;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      started_in   = started_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = req_clip[VALUE_BITS-1];
               mag_in     = req_clip[VALUE_BITS-1] ?
                            VALUE_BITS'(~req_clip + VALUE_BITS'(1)) : req_clip;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               dig_cnt_in = DIG_CNT_W'(DIGITS - 1);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!started_ff && top_digit == '0 && dig_cnt_ff != '0) begin
               // drop a leading zero
               bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_W'(top_digit);
               rsp_last_in  = (dig_cnt_ff == '0);
               started_in   = 1'b1;
               bcd_in       = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               if (dig_cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

`include "int128_to_decimal_text_assert.svh"

   `I2DT_ASSERT_NEXT(a_accept_starts_conv, clock, reset, req_valid && req_ready, state_ff == ST_CONV)
   `I2DT_ASSERT_NOW(a_conv_count_live, clock, reset, state_ff == ST_CONV, bit_cnt_ff != '0)
   `I2DT_ASSERT_NOW(a_sign_only_negative, clock, reset, state_ff == ST_SIGN, neg_ff)
   `I2DT_ASSERT_NOW(a_minus_not_last, clock, reset, rsp_valid_ff && rsp_char_ff == CHAR_MINUS, !rsp_last_ff)

endmodule
